/* rtl/stl_pkg.sv */
`timescale 1ns / 1ps

package stl_pkg;

   localparam int MODE_W = 5;
   localparam int KIND_W = 5;

   // Token kinds; the pending lexer modes reuse the codes up to K_OPER.
   localparam logic [KIND_W-1:0] K_IDENT    = 5'd0;
   localparam logic [KIND_W-1:0] K_NUMBER   = 5'd1;
   localparam logic [KIND_W-1:0] K_DECIMAL  = 5'd2;
   localparam logic [KIND_W-1:0] K_STRING   = 5'd3;
   localparam logic [KIND_W-1:0] K_CHAR     = 5'd4;
   localparam logic [KIND_W-1:0] K_OPER     = 5'd5;
   localparam logic [KIND_W-1:0] K_ASSIGN   = 5'd6;
   localparam logic [KIND_W-1:0] K_LPAREN   = 5'd7;
   localparam logic [KIND_W-1:0] K_RPAREN   = 5'd8;
   localparam logic [KIND_W-1:0] K_LBRACE   = 5'd9;
   localparam logic [KIND_W-1:0] K_RBRACE   = 5'd10;
   localparam logic [KIND_W-1:0] K_LANGLE   = 5'd11;
   localparam logic [KIND_W-1:0] K_RANGLE   = 5'd12;
   localparam logic [KIND_W-1:0] K_LBRACKET = 5'd13;
   localparam logic [KIND_W-1:0] K_RBRACKET = 5'd14;
   localparam logic [KIND_W-1:0] K_DOT      = 5'd15;
   localparam logic [KIND_W-1:0] K_COMMA    = 5'd16;
   localparam logic [KIND_W-1:0] K_SEMI     = 5'd17;
   localparam logic [KIND_W-1:0] K_COLON    = 5'd18;
   localparam logic [KIND_W-1:0] K_SPECIAL  = 5'd19;
   localparam logic [KIND_W-1:0] K_EOL      = 5'd20;

   localparam logic [MODE_W-1:0] MODE_IDLE    = 5'd30;
   localparam logic [MODE_W-1:0] MODE_DISCARD = 5'd31;

   // Input function codes.
   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FL_RD,
      S_FL_EMIT,
      S_SINGLE,
      S_FINISH
   } state_type;

   // What one input item does to the lexer.
   typedef struct packed {
      logic              pre_app;     // append the byte before the flush
      logic              flush;       // emit the pending token and clear it
      logic              single;      // emit a one-item token afterwards
      logic [KIND_W-1:0] single_kind;
      logic              single_has;
      logic              post_app;    // append the byte to the new token
      logic              clear;       // text length and overflow start over
      logic [MODE_W-1:0] new_mode;
   } action_type;

   typedef struct packed {
      logic capture;
      logic rd;
      logic emit_flush;
      logic emit_single;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic flush_go;
      logic single_go;
      logic single_pend;
      logic flush_last;
   } sts_type;

endpackage

/* rtl/source_text_lexer_unit.sv */
`timescale 1ns / 1ps

// Byte-serial lexical tokenizer. Each input item carries one source byte
// (tuser low) or an end-of-input mark (tuser high), and every token that the
// item finishes leaves as a run of result items, one per text character, with
// tlast on the final item that the input caused; an input that finishes no
// token gives no result; an empty token gives one item without a character.
// The lexer takes no new input item until it has put out every result item
// of the current one, and a consumer stall on the output holds it up. A
// single-character token or an end-of-line comes after any token that the
// same byte finishes. Each token character is read from the token buffer, a
// memory of MAX_TOKEN_LEN bytes with a registered read, and then loaded into
// the output register. Characters beyond MAX_TOKEN_LEN are dropped and the
// token's items carry the truncated flag. An unknown byte makes the lexer
// drop everything until the next end-of-input mark.

module source_text_lexer_unit import stl_pkg::*; #(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic [0:0]  req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] char_out, [8] token_end, [9] truncated
   output logic [5:0]  rsp_tuser,   // [4:0] token_kind, [5] has_char
   output logic        rsp_tlast    // run_end
);

   cmd_type           cmd;
   sts_type           sts;
   logic [KIND_W-1:0] rsp_kind;
   logic [7:0]        rsp_char;
   logic              rsp_has_char;
   logic              rsp_token_end;
   logic              rsp_truncated;
   logic              rsp_run_end;

   stl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stl_datapath #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_func      (req_tuser[0]),
      .req_char      (req_tdata),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_kind      (rsp_kind),
      .rsp_char      (rsp_char),
      .rsp_has_char  (rsp_has_char),
      .rsp_token_end (rsp_token_end),
      .rsp_truncated (rsp_truncated),
      .rsp_run_end   (rsp_run_end)
   );

   // Pack the result item onto the stream.
   assign rsp_tdata = {6'd0, rsp_truncated, rsp_token_end, rsp_char};
   assign rsp_tuser = {rsp_has_char, rsp_kind};
   assign rsp_tlast = rsp_run_end;

endmodule

/* rtl/stl_ram.sv */
`timescale 1ns / 1ps

module stl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/stl_ctrl.sv */
`timescale 1ns / 1ps

module stl_ctrl import stl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands to the datapath.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               priority if (sts.flush_go) begin
                  state_in = S_FL_RD;
               end else if (sts.single_go) begin
                  state_in = S_SINGLE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FL_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_FL_EMIT;
         end
         S_FL_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_flush = 1'b1;
               priority if (!sts.flush_last) begin
                  state_in = S_FL_RD;
               end else if (sts.single_pend) begin
                  state_in = S_SINGLE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SINGLE: begin
            if (sts.out_free) begin
               cmd.emit_single = 1'b1;
               state_in        = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/stl_datapath.sv */
`timescale 1ns / 1ps

module stl_datapath import stl_pkg::*; #(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_func,
   input  logic [7:0]        req_char,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [7:0]        rsp_char,
   output logic              rsp_has_char,
   output logic              rsp_token_end,
   output logic              rsp_truncated,
   output logic              rsp_run_end
);

   localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
   localparam int ADDR_W = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);

   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_BACKTICK = 8'h60;

   logic [MODE_W-1:0] mode_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              ovf_ff;
   action_type        act_ff;
   logic [7:0]        ch_ff;
   logic [LEN_W-1:0]  idx_ff;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [7:0]        char_ff;
   logic              has_ff;
   logic              end_ff;
   logic              trunc_ff;
   logic              run_ff;
   logic [KIND_W-1:0] kind_in;
   logic [7:0]        char_in;
   logic              has_in;
   logic              end_in;
   logic              trunc_in;
   logic              run_in;

   action_type        act;
   logic              lit;
   logic              is_letter;
   logic              is_digit;
   logic              go_disc;
   logic [KIND_W:0]   pk;
   logic              pending;

   logic [LEN_W-1:0]  base_len;
   logic              base_ovf;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic [7:0]        ram_rd_data;
   logic              flush_last;

   // Punctuation kind of a byte; the top bit flags a match.
   function automatic logic [KIND_W:0] punct_kind(input logic [7:0] c);
      logic [KIND_W:0] r;
      r = '0;
      unique case (c)
         "(":     r = {1'b1, K_LPAREN};
         ")":     r = {1'b1, K_RPAREN};
         "{":     r = {1'b1, K_LBRACE};
         "}":     r = {1'b1, K_RBRACE};
         "<":     r = {1'b1, K_LANGLE};
         ">":     r = {1'b1, K_RANGLE};
         "[":     r = {1'b1, K_LBRACKET};
         "]":     r = {1'b1, K_RBRACKET};
         ",":     r = {1'b1, K_COMMA};
         ";":     r = {1'b1, K_SEMI};
         ":":     r = {1'b1, K_COLON};
         "&", "#", "@", "!", "|", "?", "^", CH_BACKTICK: r = {1'b1, K_SPECIAL};
         default: r = '0;
      endcase
      return r;
   endfunction

   // Decode what the offered item does, given the current mode.
   always_comb begin
      act       = '0;
      act.new_mode = mode_ff;
      go_disc   = 1'b0;
      lit       = (mode_ff == K_STRING) || (mode_ff == K_CHAR);
      is_letter = ((req_char >= "a") && (req_char <= "z")) ||
                  ((req_char >= "A") && (req_char <= "Z"));
      is_digit  = (req_char >= "0") && (req_char <= "9");
      pk        = punct_kind(req_char);
      priority if (req_func == FUNC_FLUSH) begin
         act.flush    = 1'b1;
         act.new_mode = MODE_IDLE;
      end else if (mode_ff == MODE_DISCARD) begin
         act.new_mode = MODE_DISCARD;
      end else if (is_letter) begin
         priority if (mode_ff == MODE_IDLE) begin
            act.new_mode = K_IDENT;
            act.post_app = 1'b1;
         end else if (mode_ff == K_IDENT || lit) begin
            act.post_app = 1'b1;
         end else begin
            go_disc = 1'b1;
         end
      end else if (is_digit) begin
         if (mode_ff == MODE_IDLE || mode_ff == K_OPER) begin
            act.new_mode = K_NUMBER;
         end
         act.post_app = 1'b1;
      end else if (pk[KIND_W] || req_char == "=" || req_char == "+" ||
                   req_char == "*" || req_char == "/" || req_char == "%") begin
         if (lit) begin
            act.post_app = 1'b1;
         end else begin
            act.flush       = 1'b1;
            act.new_mode    = MODE_IDLE;
            act.single      = 1'b1;
            act.single_has  = 1'b1;
            priority if (pk[KIND_W]) begin
               act.single_kind = pk[KIND_W-1:0];
            end else if (req_char == "=") begin
               act.single_kind = K_ASSIGN;
            end else begin
               act.single_kind = K_OPER;
            end
         end
      end else begin
         unique case (req_char)
            "-": begin
               if (lit) begin
                  act.post_app = 1'b1;
               end else begin
                  act.flush    = 1'b1;
                  act.new_mode = K_OPER;
                  act.post_app = 1'b1;
               end
            end
            "\\": begin
               priority if (lit) begin
                  act.post_app = 1'b1;
               end else if (mode_ff == MODE_IDLE) begin
                  go_disc = 1'b1;
               end else begin
                  act.flush    = 1'b1;
                  act.new_mode = MODE_IDLE;
               end
            end
            " ", "\t": begin
               if (lit) begin
                  act.post_app = 1'b1;
               end else begin
                  act.flush    = 1'b1;
                  act.new_mode = MODE_IDLE;
               end
            end
            "\n", CH_CR: begin
               if (lit) begin
                  act.post_app = 1'b1;
               end else begin
                  act.flush       = 1'b1;
                  act.new_mode    = MODE_IDLE;
                  act.single      = 1'b1;
                  act.single_kind = K_EOL;
               end
            end
            "\"": begin
               priority if (mode_ff == MODE_IDLE) begin
                  act.new_mode = K_STRING;
               end else if (mode_ff == K_STRING) begin
                  act.flush    = 1'b1;
                  act.new_mode = MODE_IDLE;
               end else begin
                  go_disc = 1'b1;
               end
            end
            "'": begin
               priority if (mode_ff == MODE_IDLE) begin
                  act.new_mode = K_CHAR;
                  act.post_app = 1'b1;
               end else if (mode_ff == K_CHAR) begin
                  act.pre_app  = 1'b1;
                  act.flush    = 1'b1;
                  act.new_mode = MODE_IDLE;
               end else if (mode_ff == K_STRING) begin
                  act.post_app = 1'b1;
               end else begin
                  go_disc = 1'b1;
               end
            end
            ".": begin
               priority if (mode_ff == K_NUMBER) begin
                  act.new_mode = K_DECIMAL;
                  act.post_app = 1'b1;
               end else if (lit) begin
                  act.post_app = 1'b1;
               end else begin
                  act.flush       = 1'b1;
                  act.new_mode    = MODE_IDLE;
                  act.single      = 1'b1;
                  act.single_kind = K_DOT;
                  act.single_has  = 1'b1;
               end
            end
            default: begin
               go_disc = 1'b1;
            end
         endcase
      end
      if (go_disc) begin
         act.new_mode = MODE_DISCARD;
      end
      act.clear = act.flush | go_disc;
   end

   // A pending token exists only in the identifier to operator modes.
   assign pending = (mode_ff <= K_OPER);

   // Length and overflow seen by the final append of an item.
   assign base_len = act_ff.clear ? '0 : len_ff;
   assign base_ovf = act_ff.clear ? 1'b0 : ovf_ff;

   // Buffer writes: an early append at capture, the normal one at finish.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = len_ff[ADDR_W-1:0];
      ram_wr_data = req_char;
      if (cmd.capture) begin
         ram_wr_en = act.pre_app && (len_ff < MAX_LEN);
      end else if (cmd.finish) begin
         ram_wr_en   = act_ff.post_app && (base_len < MAX_LEN);
         ram_wr_addr = base_len[ADDR_W-1:0];
         ram_wr_data = ch_ff;
      end
   end

   stl_ram #(
      .WIDTH (8),
      .DEPTH (MAX_TOKEN_LEN)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Lexer state: mode, text length and overflow flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.capture) begin
         if (act.pre_app) begin
            if (len_ff < MAX_LEN) begin
               len_ff <= len_ff + LEN_W'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
      end else if (cmd.finish) begin
         mode_ff <= act_ff.new_mode;
         if (act_ff.post_app && (base_len < MAX_LEN)) begin
            len_ff <= base_len + LEN_W'(1);
            ovf_ff <= base_ovf;
         end else begin
            len_ff <= base_len;
            ovf_ff <= base_ovf | act_ff.post_app;
         end
      end
   end

   // Item being worked on and the read index into the buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
         idx_ff <= '0;
      end else if (cmd.capture) begin
         act_ff <= act;
         idx_ff <= '0;
      end else if (cmd.emit_flush) begin
         idx_ff <= idx_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff <= req_char;
      end
   end

   assign flush_last = (len_ff == '0) || ((idx_ff + LEN_W'(1)) == len_ff);

   // Next result item.
   always_comb begin
      if (cmd.emit_flush) begin
         kind_in  = mode_ff;
         char_in  = (len_ff == '0) ? 8'd0 : ram_rd_data;
         has_in   = (len_ff != '0);
         end_in   = flush_last;
         trunc_in = ovf_ff;
         run_in   = flush_last && !act_ff.single;
      end else begin
         kind_in  = act_ff.single_kind;
         char_in  = act_ff.single_has ? ch_ff : 8'd0;
         has_in   = act_ff.single_has;
         end_in   = 1'b1;
         trunc_in = 1'b0;
         run_in   = 1'b1;
      end
   end

   // Output register; it holds an item until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_flush || cmd.emit_single) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_flush || cmd.emit_single) begin
         kind_ff  <= kind_in;
         char_ff  <= char_in;
         has_ff   <= has_in;
         end_ff   <= end_in;
         trunc_ff <= trunc_in;
         run_ff   <= run_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_char      = char_ff;
   assign rsp_has_char  = has_ff;
   assign rsp_token_end = end_ff;
   assign rsp_truncated = trunc_ff;
   assign rsp_run_end   = run_ff;

   // Status to the controller.
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;
   assign sts.flush_go    = act.flush && pending;
   assign sts.single_go   = act.single;
   assign sts.single_pend = act_ff.single;
   assign sts.flush_last  = flush_last;

endmodule

/* test/lexer_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the lexer. It predicts the token items that each
// accepted input item causes and compares every accepted result with the
// oldest prediction.
module lexer_checker import stl_pkg::*; #(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic [0:0]  req_tuser,   // [0] func
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] char_out, [8] token_end, [9] truncated
   input  logic [5:0]  rsp_tuser,   // [4:0] token_kind, [5] has_char
   input  logic        rsp_tlast,   // run_end
   output int          fail_count,
   output int          due_count,
   output int          checked_count,
   output int          token_count
);

   localparam int MAX_REPORTS = 30;

   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_APOS     = 8'h27;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_BACKTICK = 8'h60;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        ch;
      logic              has_char;
      logic              token_end;
      logic              truncated;
      logic              run_end;
   } token_char_type;

   // Token characters still to come out of the block, oldest first.
   token_char_type token_chars_due[$];
   // Token characters caused by the input item being predicted.
   token_char_type step_chars[$];

   // Shadow of the lexer state.
   logic [MODE_W-1:0] lex_mode;
   logic [7:0]        text_buf [0:MAX_TOKEN_LEN-1];
   int                text_len;
   logic              text_cut;

   int fail_total;
   int checked_total;
   int tokens_total;

   task automatic report_mismatch(string msg);
      fail_total++;
      if (fail_total <= MAX_REPORTS)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   function automatic void push_char(logic [KIND_W-1:0] kind, logic [7:0] ch,
                                     logic has, logic tend, logic trunc);
      token_char_type item;
      item.kind      = kind;
      item.ch        = ch;
      item.has_char  = has;
      item.token_end = tend;
      item.truncated = trunc;
      item.run_end   = 1'b0;
      step_chars.insert(step_chars.size(), item);
   endfunction

   function automatic void clear_text();
      text_len = 0;
      text_cut = 1'b0;
   endfunction

   // Characters past the buffer are dropped and mark the token as cut.
   function automatic void append_char(logic [7:0] ch);
      if (text_len < MAX_TOKEN_LEN) begin
         text_buf[text_len] = ch;
         text_len++;
      end else begin
         text_cut = 1'b1;
      end
   endfunction

   // Emit the pending token, if there is one, and go back to idle.
   function automatic void flush_token();
      if (lex_mode <= K_OPER) begin
         if (text_len == 0) begin
            push_char(lex_mode, 8'h00, 1'b0, 1'b1, text_cut);
         end else begin
            for (int i = 0; i < text_len; i++)
               push_char(lex_mode, text_buf[i], 1'b1, i == text_len - 1, text_cut);
         end
      end
      lex_mode = MODE_IDLE;
      clear_text();
   endfunction

   function automatic void enter_discard();
      lex_mode = MODE_DISCARD;
      clear_text();
   endfunction

   function automatic void emit_single(logic [KIND_W-1:0] kind, logic [7:0] ch);
      flush_token();
      push_char(kind, ch, 1'b1, 1'b1, 1'b0);
   endfunction

   // Kind of a one-character punctuation token, or -1 for any other byte.
   function automatic int punct_kind(logic [7:0] ch);
      case (ch)
         "(": return int'(K_LPAREN);
         ")": return int'(K_RPAREN);
         "{": return int'(K_LBRACE);
         "}": return int'(K_RBRACE);
         "<": return int'(K_LANGLE);
         ">": return int'(K_RANGLE);
         "[": return int'(K_LBRACKET);
         "]": return int'(K_RBRACKET);
         ",": return int'(K_COMMA);
         ";": return int'(K_SEMI);
         ":": return int'(K_COLON);
         "&", "#", "@", "!", "|", "?", "^", CH_BACKTICK: return int'(K_SPECIAL);
         default: return -1;
      endcase
   endfunction

   function automatic void lex_source_byte(logic [7:0] ch);
      logic in_literal;
      int   pk;
      in_literal = (lex_mode == K_STRING) || (lex_mode == K_CHAR);
      pk = punct_kind(ch);
      if (lex_mode == MODE_DISCARD) begin
         // Everything is dropped until the end of input.
      end else if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) begin
         if (lex_mode == MODE_IDLE) begin
            lex_mode = K_IDENT;
            append_char(ch);
         end else if (lex_mode == K_IDENT || in_literal) begin
            append_char(ch);
         end else begin
            enter_discard();
         end
      end else if (ch >= "0" && ch <= "9") begin
         // A digit after a pending minus turns it into a number.
         if (lex_mode == MODE_IDLE || lex_mode == K_OPER)
            lex_mode = K_NUMBER;
         append_char(ch);
      end else if (pk >= 0) begin
         if (in_literal)
            append_char(ch);
         else
            emit_single(pk[KIND_W-1:0], ch);
      end else begin
         case (ch)
            "=": begin
               if (in_literal) append_char(ch);
               else emit_single(K_ASSIGN, ch);
            end
            "+", "*", "/", "%": begin
               if (in_literal) append_char(ch);
               else emit_single(K_OPER, ch);
            end
            "-": begin
               if (in_literal) begin
                  append_char(ch);
               end else begin
                  flush_token();
                  lex_mode = K_OPER;
                  append_char(ch);
               end
            end
            CH_BSLASH: begin
               if (in_literal) append_char(ch);
               else if (lex_mode == MODE_IDLE) enter_discard();
               else flush_token();
            end
            " ", CH_TAB: begin
               if (in_literal) append_char(ch);
               else flush_token();
            end
            CH_LF, CH_CR: begin
               if (in_literal) begin
                  append_char(ch);
               end else begin
                  flush_token();
                  push_char(K_EOL, 8'h00, 1'b0, 1'b1, 1'b0);
               end
            end
            CH_QUOTE: begin
               // String text leaves out both quotes.
               if (lex_mode == MODE_IDLE) lex_mode = K_STRING;
               else if (lex_mode == K_STRING) flush_token();
               else enter_discard();
            end
            CH_APOS: begin
               // Char text keeps both quotes.
               if (lex_mode == MODE_IDLE) begin
                  lex_mode = K_CHAR;
                  append_char(ch);
               end else if (lex_mode == K_CHAR) begin
                  append_char(ch);
                  flush_token();
               end else if (lex_mode == K_STRING) begin
                  append_char(ch);
               end else begin
                  enter_discard();
               end
            end
            ".": begin
               if (lex_mode == K_NUMBER) begin
                  lex_mode = K_DECIMAL;
                  append_char(ch);
               end else if (in_literal) begin
                  append_char(ch);
               end else begin
                  emit_single(K_DOT, ch);
               end
            end
            default: enter_discard();
         endcase
      end
   endfunction

   // Work out the items of one accepted input and queue them.
   function automatic void predict_item(logic func, logic [7:0] ch);
      token_char_type item;
      step_chars.delete();
      if (func == FUNC_FLUSH) begin
         if (lex_mode == MODE_DISCARD)
            lex_mode = MODE_IDLE;
         flush_token();
      end else begin
         lex_source_byte(ch);
      end
      for (int i = 0; i < step_chars.size(); i++) begin
         item = step_chars[i];
         item.run_end = (i == step_chars.size() - 1);
         token_chars_due.insert(token_chars_due.size(), item);
      end
   endfunction

   // Inputs are taken before results, since no result can leave in the
   // same cycle as the input that causes it.
   always @(posedge clock) begin : watch
      token_char_type want;
      if (reset) begin
         lex_mode = MODE_IDLE;
         clear_text();
         token_chars_due.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_item(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (token_chars_due.size() == 0) begin
               report_mismatch($sformatf("result item (char_out %0d) with nothing expected",
                                         rsp_tdata[7:0]));
            end else begin
               want = token_chars_due.pop_front();
               check_field("token_kind", 8'(rsp_tuser[KIND_W-1:0]), 8'(want.kind));
               check_field("char_out", rsp_tdata[7:0], want.ch);
               check_field("has_char", 8'(rsp_tuser[5]), 8'(want.has_char));
               check_field("token_end", 8'(rsp_tdata[8]), 8'(want.token_end));
               check_field("truncated", 8'(rsp_tdata[9]), 8'(want.truncated));
               check_field("run_end", 8'(rsp_tlast), 8'(want.run_end));
               checked_total++;
               if (want.token_end)
                  tokens_total++;
            end
         end
      end
      fail_count    <= fail_total;
      due_count     <= token_chars_due.size();
      checked_count <= checked_total;
      token_count   <= tokens_total;
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import stl_pkg::*;

   localparam int MAX_TOKEN_LEN = 32;
   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 400;
   localparam int PHASE_ITEMS   = 100;
   localparam int DRAIN_CYCLES  = 100;
   localparam int CYCLE_LIMIT   = 500000;

   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_APOS     = 8'h27;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_BACKTICK = 8'h60;

   typedef enum int {
      TRAFFIC_STEADY,
      TRAFFIC_SENDER_GAPS,
      TRAFFIC_RECEIVER_STALLS,
      TRAFFIC_BOTH
   } traffic_phase_e;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] char_in
   logic [0:0]  req_tuser  = '0;   // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] char_out, [8] token_end, [9] truncated
   logic [5:0]  rsp_tuser;         // [4:0] token_kind, [5] has_char
   logic        rsp_tlast;

   int fail_count;
   int due_count;
   int checked_count;
   int token_count;

   int idle_pct       = 0;
   int stall_pct      = 0;
   int items_sent     = 0;
   int directed_items = 0;
   int cycle_count    = 0;

   string letter_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   string symbol_set = "+*/%=-()[]{}<>,;:&#@!|?^.";

   source_text_lexer_unit #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   lexer_checker #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .due_count     (due_count),
      .checked_count (checked_count),
      .token_count   (token_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // The receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run timed out after %0d cycles with %0d items outstanding.",
                  cycle_count, due_count);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         cycle_count <= cycle_count + 1;
      end
   end

   task automatic set_traffic(traffic_phase_e phase);
      case (phase)
         TRAFFIC_STEADY:          begin idle_pct = 0;  stall_pct = 0;  end
         TRAFFIC_SENDER_GAPS:     begin idle_pct = 50; stall_pct = 0;  end
         TRAFFIC_RECEIVER_STALLS: begin idle_pct = 0;  stall_pct = 50; end
         default:                 begin idle_pct = 22; stall_pct = 22; end
      endcase
   endtask

   // Offer one item and return at the edge where it is taken; tvalid stays
   // high so that the next item can follow without a gap.
   task automatic send_item(logic func, logic [7:0] ch);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] ch);
      send_item(FUNC_BYTE, ch);
   endtask

   task automatic send_flush();
      send_item(FUNC_FLUSH, 8'h00);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_letter();
      return letter_set[$urandom_range(letter_set.len() - 1)];
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_symbol();
      if ($urandom_range(25) == 0)
         return CH_BACKTICK;
      return symbol_set[$urandom_range(symbol_set.len() - 1)];
   endfunction

   // A byte that a string or char literal keeps as text.
   function automatic logic [7:0] rand_text_char(logic allow_apos);
      case ($urandom_range(9))
         0, 1, 2, 3: return rand_letter();
         4, 5:       return rand_digit();
         6, 7:       return rand_symbol();
         8: begin
            case ($urandom_range(4))
               0:       return CH_TAB;
               1:       return CH_LF;
               2:       return CH_CR;
               3:       return CH_BSLASH;
               default: return " ";
            endcase
         end
         default:    return allow_apos ? CH_APOS : " ";
      endcase
   endfunction

   // Whitespace or a line break after a token; a backslash may end a
   // pending identifier or number too.
   task automatic send_separator(logic allow_bslash);
      case ($urandom_range(9))
         0, 1, 2, 3: send_byte(" ");
         4:          send_byte(CH_TAB);
         5:          send_byte(CH_LF);
         6:          send_byte(CH_CR);
         7:          if (allow_bslash) send_byte(CH_BSLASH); else send_byte(" ");
         default:    ;
      endcase
   endtask

   // One well-formed token with random content, or now and then noise, a
   // broken sequence or an end-of-input mark.
   task automatic send_random_token();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 20) begin
         send_byte(rand_letter());
         n = $urandom_range(7);
         repeat (n) send_byte(($urandom_range(2) == 0) ? rand_digit() : rand_letter());
         send_separator(1'b1);
      end else if (pick < 32) begin
         if ($urandom_range(2) == 0)
            send_byte("-");
         n = $urandom_range(1, 6);
         repeat (n) send_byte(rand_digit());
         send_separator(1'b1);
      end else if (pick < 40) begin
         n = $urandom_range(1, 3);
         repeat (n) send_byte(rand_digit());
         send_byte(".");
         n = $urandom_range(0, 3);
         repeat (n) send_byte(rand_digit());
         send_separator(1'b1);
      end else if (pick < 50) begin
         send_byte(CH_QUOTE);
         n = $urandom_range(0, 6);
         repeat (n) send_byte(rand_text_char(1'b1));
         if ($urandom_range(9) != 0)
            send_byte(CH_QUOTE);
         send_separator(1'b0);
      end else if (pick < 58) begin
         send_byte(CH_APOS);
         n = $urandom_range(0, 3);
         repeat (n) send_byte(rand_text_char(1'b0));
         send_byte(CH_APOS);
         send_separator(1'b0);
      end else if (pick < 72) begin
         send_byte(rand_symbol());
         if ($urandom_range(3) == 0)
            send_separator(1'b0);
      end else if (pick < 78) begin
         // Tokens around the buffer size, so that some get cut.
         n = $urandom_range(MAX_TOKEN_LEN - 4, MAX_TOKEN_LEN + 8);
         case ($urandom_range(2))
            0: begin
               send_byte(rand_letter());
               repeat (n - 1) send_byte(rand_letter());
            end
            1: repeat (n) send_byte(rand_digit());
            default: begin
               send_byte(CH_QUOTE);
               repeat (n) send_byte(rand_text_char(1'b1));
               send_byte(CH_QUOTE);
            end
         endcase
         if ($urandom_range(1) == 0) send_byte(rand_symbol());
         else send_separator(1'b0);
      end else if (pick < 84) begin
         send_byte(8'($urandom_range(255)));
         send_flush();
      end else if (pick < 90) begin
         case ($urandom_range(4))
            0: begin send_byte(rand_digit()); send_byte(rand_letter()); end
            1: begin send_byte("-");          send_byte(rand_letter()); end
            2: begin send_byte(rand_letter()); send_byte(CH_APOS);      end
            3: begin send_byte(rand_digit()); send_byte(CH_QUOTE);      end
            default: send_byte(CH_BSLASH);
         endcase
         send_flush();
      end else if (pick < 95) begin
         send_flush();
      end else begin
         send_separator(1'b0);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: identifier, decimal, string, char, operator, assign and EOL
      // tokens, a minus before a digit, an empty string, a carriage return, a
      // backslash after an identifier, the byte extremes leading into the discard
      // mode, and an unterminated string closed by the end of input.
      set_traffic(TRAFFIC_STEADY);
      send_text("Az9 -0.5 \"\"'x'\t+=");
      send_byte(CH_CR);
      send_text("a\\");
      send_byte(8'hFF);
      send_byte(8'h00);
      send_flush();
      send_text("\"q");
      send_flush();
      send_byte(CH_LF);
      directed_items = items_sent;

      // Random part, stepping through the traffic phases.
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         set_traffic(traffic_phase_e'(((items_sent - directed_items) / PHASE_ITEMS) % 4));
         send_random_token();
      end
      send_flush();
      req_tvalid <= 1'b0;
      set_traffic(TRAFFIC_STEADY);

      // Wait for every predicted item, then let any late result show up.
      @(posedge clock);
      while (due_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d input items (%0d directed) under steady, gapped and stalled traffic.",
               items_sent, directed_items);
      $display("Checked %0d result items in %0d tokens, %0d mismatches.",
               checked_count, token_count, fail_count);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
